FILE: rtl/core/cap_pkg.sv
// shared constants, types and helpers for the co-occurrence association predictor
// no dependencies
package cap_pkg;

    localparam int NUM_FEAT   = 64;
    localparam int FEAT_W     = 6;
    localparam int MAX_EXP    = 32;
    localparam int EXP_W      = 5;
    localparam int LEN_W      = 6;
    localparam int CNT_W      = 16;
    localparam int PAIR_AW    = 2 * FEAT_W;
    localparam int SCORE_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int NUM_W      = CNT_W + FRAC_W + FEAT_W;
    localparam int SET_W      = FEAT_W + 1;

    localparam logic [CNT_W-1:0]   CNT_MAX      = '1;
    localparam logic [SCORE_W-1:0] SCORE_ONE    = 17'h10000;
    localparam logic [SCORE_W-1:0] THRESH_RESET = 17'd3276;

    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_QUERY   = 1'b1;

    typedef struct packed {
        logic                pair_we;
        logic [PAIR_AW-1:0]  pair_waddr;
        logic [CNT_W-1:0]    pair_wdata;
        logic [PAIR_AW-1:0]  pair_raddr;
        logic                fc_we;
        logic [FEAT_W-1:0]   fc_waddr;
        logic [CNT_W-1:0]    fc_wdata;
        logic [FEAT_W-1:0]   fc_raddr;
        logic                buf_we;
        logic [EXP_W-1:0]    buf_waddr;
        logic [FEAT_W-1:0]   buf_wdata;
        logic [EXP_W-1:0]    buf_raddr;
    } cap_mem_req_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                 input logic [1:0] d);
        logic [CNT_W:0] s;
        s = {1'b0, v} + {{(CNT_W-1){1'b0}}, d};
        if (s > {1'b0, CNT_MAX})
            return CNT_MAX;
        return s[CNT_W-1:0];
    endfunction

endpackage

FILE: rtl/core/cap_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on cap_pkg
module cap_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cap_pkg::NUM_W-1:0]   num,
    input  logic [cap_pkg::CNT_W-1:0]   den,
    output logic                        done,
    output logic [cap_pkg::NUM_W-1:0]   quot
);

    logic [cap_pkg::NUM_W-1:0] num_reg, num_next;
    logic [cap_pkg::CNT_W-1:0] den_reg, den_next;
    logic [cap_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic [5:0]                cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [cap_pkg::CNT_W:0]   trial;
    logic [cap_pkg::CNT_W:0]   diff;
    logic                      ge;

    always_comb
    begin
        trial     = {rem_reg, num_reg[cap_pkg::NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        diff      = trial - {1'b0, den_reg};
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            cnt_next  = 6'(cap_pkg::NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[cap_pkg::NUM_W-2:0], ge};
            rem_next = ge ? diff[cap_pkg::CNT_W-1:0] : trial[cap_pkg::CNT_W-1:0];
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

FILE: rtl/core/cap_store.sv
// pair count, feature count and experience buffer memories, registered reads
// depends on cap_pkg
module cap_store (
    input  logic                         clk,
    input  cap_pkg::cap_mem_req_t        req,
    output logic [cap_pkg::CNT_W-1:0]    pair_rdata,
    output logic [cap_pkg::CNT_W-1:0]    fc_rdata,
    output logic [cap_pkg::FEAT_W-1:0]   buf_rdata
);

    logic [cap_pkg::CNT_W-1:0]  pair_mem [0:(1 << cap_pkg::PAIR_AW)-1];
    logic [cap_pkg::CNT_W-1:0]  fc_mem   [0:cap_pkg::NUM_FEAT-1];
    logic [cap_pkg::FEAT_W-1:0] buf_mem  [0:cap_pkg::MAX_EXP-1];

    always_ff @(posedge clk)
    begin
        if (req.pair_we)
            pair_mem[req.pair_waddr] <= req.pair_wdata;
        pair_rdata <= pair_mem[req.pair_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (req.fc_we)
            fc_mem[req.fc_waddr] <= req.fc_wdata;
        fc_rdata <= fc_mem[req.fc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (req.buf_we)
            buf_mem[req.buf_waddr] <= req.buf_wdata;
        buf_rdata <= buf_mem[req.buf_raddr];
    end

endmodule

FILE: rtl/core/cooccurrence_association_predictor_top.sv
// top level of the co-occurrence association predictor: sequencer and result register
// depends on cap_pkg, cap_store, cap_div
//
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+--------------------------------------
// input    | in        | in_valid, in_stall  | opcode, feature_index, last_feature
// output   | out       | out_valid, out_stall| predicted_feature, score, last_of_run
// config   | in        | cfg_we              | cfg_wdata (prediction_threshold)
//
// after reset the count memories are cleared, with in_stall high
// observe: bump the feature count, then update both pair counts per buffered
// feature (one for a repeated index) and buffer the feature; query end walks 64
// features by 64 known slots, with each division in the one shared divider
// a result waits in the output register while the next score is worked out
module cooccurrence_association_predictor_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          opcode,
    input  logic [cap_pkg::FEAT_W-1:0]    feature_index,
    input  logic                          last_feature,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cap_pkg::FEAT_W-1:0]    predicted_feature,
    output logic [cap_pkg::SCORE_W-1:0]   score,
    output logic                          last_of_run,
    input  logic                          cfg_we,
    input  logic [cap_pkg::SCORE_W-1:0]   cfg_wdata
);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_RDF   = 5'd2;
    localparam logic [4:0] S_FCHK  = 5'd3;
    localparam logic [4:0] S_OBUF  = 5'd4;
    localparam logic [4:0] S_ORA   = 5'd5;
    localparam logic [4:0] S_OWA   = 5'd6;
    localparam logic [4:0] S_OWB   = 5'd7;
    localparam logic [4:0] S_OEND  = 5'd8;
    localparam logic [4:0] S_PJ    = 5'd9;
    localparam logic [4:0] S_PJCHK = 5'd10;
    localparam logic [4:0] S_PK    = 5'd11;
    localparam logic [4:0] S_PKD   = 5'd12;
    localparam logic [4:0] S_PKW   = 5'd13;
    localparam logic [4:0] S_PAVG  = 5'd14;
    localparam logic [4:0] S_PAW   = 5'd15;
    localparam logic [4:0] S_PEMIT = 5'd16;
    localparam logic [4:0] S_PNEXT = 5'd17;
    localparam logic [4:0] S_PFIN  = 5'd18;

    logic [4:0]                   state_reg, state_next;
    logic [cap_pkg::PAIR_AW-1:0]  clr_reg, clr_next;
    logic [cap_pkg::SCORE_W-1:0]  thresh_reg, thresh_next;
    logic                         op_reg, op_next;
    logic [cap_pkg::FEAT_W-1:0]   f_reg, f_next;
    logic                         last_reg, last_next;
    logic [cap_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [cap_pkg::LEN_W-1:0]    n_reg, n_next;
    logic [cap_pkg::FEAT_W-1:0]   b_reg, b_next;
    logic [cap_pkg::NUM_FEAT-1:0] known_reg, known_next;
    logic [cap_pkg::SET_W-1:0]    set_reg, set_next;
    logic [cap_pkg::FEAT_W-1:0]   j_reg, j_next;
    logic [cap_pkg::FEAT_W-1:0]   k_reg, k_next;
    logic [cap_pkg::NUM_W-1:0]    sum_reg, sum_next;
    logic [cap_pkg::SCORE_W-1:0]  cand_reg, cand_next;
    logic                         pend_v_reg, pend_v_next;
    logic [cap_pkg::FEAT_W-1:0]   pend_j_reg, pend_j_next;
    logic [cap_pkg::SCORE_W-1:0]  pend_s_reg, pend_s_next;
    logic                         out_v_reg, out_v_next;
    logic [cap_pkg::FEAT_W-1:0]   out_j_reg, out_j_next;
    logic [cap_pkg::SCORE_W-1:0]  out_s_reg, out_s_next;
    logic                         out_l_reg, out_l_next;

    cap_pkg::cap_mem_req_t        req;
    logic [cap_pkg::CNT_W-1:0]    pair_rdata;
    logic [cap_pkg::CNT_W-1:0]    fc_rdata;
    logic [cap_pkg::FEAT_W-1:0]   buf_rdata;
    logic                         div_start;
    logic [cap_pkg::NUM_W-1:0]    div_num;
    logic [cap_pkg::CNT_W-1:0]    div_den;
    logic                         div_done;
    logic [cap_pkg::NUM_W-1:0]    div_quot;
    logic                         out_free;
    logic [cap_pkg::SCORE_W-1:0]  avg;

    cap_store u_store (
        .clk        (clk),
        .req        (req),
        .pair_rdata (pair_rdata),
        .fc_rdata   (fc_rdata),
        .buf_rdata  (buf_rdata)
    );

    cap_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        thresh_next = cfg_we ? cfg_wdata : thresh_reg;
        op_next     = op_reg;
        f_next      = f_reg;
        last_next   = last_reg;
        len_next    = len_reg;
        n_next      = n_reg;
        b_next      = b_reg;
        known_next  = known_reg;
        set_next    = set_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        sum_next    = sum_reg;
        cand_next   = cand_reg;
        pend_v_next = pend_v_reg;
        pend_j_next = pend_j_reg;
        pend_s_next = pend_s_reg;
        out_free    = !out_v_reg || !out_stall;
        out_v_next  = out_v_reg && out_stall;
        out_j_next  = out_j_reg;
        out_s_next  = out_s_reg;
        out_l_next  = out_l_reg;
        req         = '0;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        avg         = (div_quot > cap_pkg::NUM_W'(cap_pkg::SCORE_ONE))
                      ? cap_pkg::SCORE_ONE : div_quot[cap_pkg::SCORE_W-1:0];

        case (state_reg)
            S_CLR:
            begin
                req.pair_we    = 1'b1;
                req.pair_waddr = clr_reg;
                req.fc_we      = 1'b1;
                req.fc_waddr   = clr_reg[cap_pkg::FEAT_W-1:0];
                clr_next       = clr_reg + 1'b1;
                if (&clr_reg)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    f_next     = feature_index;
                    last_next  = last_feature;
                    state_next = S_RDF;
                end
            end
            S_RDF:
            begin
                req.fc_raddr = f_reg;
                state_next   = S_FCHK;
            end
            S_FCHK:
            begin
                if (op_reg == cap_pkg::OP_OBSERVE)
                begin
                    if (len_reg == cap_pkg::LEN_W'(cap_pkg::MAX_EXP))
                    begin
                        if (last_reg)
                            len_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        req.fc_we    = 1'b1;
                        req.fc_waddr = f_reg;
                        req.fc_wdata = cap_pkg::sat_add(fc_rdata, 2'd1);
                        n_next       = '0;
                        state_next   = S_OBUF;
                    end
                end
                else
                begin
                    if (fc_rdata != '0 && !known_reg[f_reg])
                    begin
                        known_next[f_reg] = 1'b1;
                        set_next          = set_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                    if (last_reg && (set_next != '0))
                    begin
                        j_next      = '0;
                        pend_v_next = 1'b0;
                        state_next  = S_PJ;
                    end
                end
            end
            S_OBUF:
            begin
                req.buf_raddr = n_reg[cap_pkg::EXP_W-1:0];
                state_next    = (n_reg == len_reg) ? S_OEND : S_ORA;
            end
            S_ORA:
            begin
                b_next         = buf_rdata;
                req.pair_raddr = {buf_rdata, f_reg};
                state_next     = S_OWA;
            end
            S_OWA:
            begin
                req.pair_we    = 1'b1;
                req.pair_waddr = {b_reg, f_reg};
                if (b_reg == f_reg)
                begin
                    req.pair_wdata = cap_pkg::sat_add(pair_rdata, 2'd2);
                    n_next         = n_reg + 1'b1;
                    state_next     = S_OBUF;
                end
                else
                begin
                    req.pair_wdata = cap_pkg::sat_add(pair_rdata, 2'd1);
                    req.pair_raddr = {f_reg, b_reg};
                    state_next     = S_OWB;
                end
            end
            S_OWB:
            begin
                req.pair_we    = 1'b1;
                req.pair_waddr = {f_reg, b_reg};
                req.pair_wdata = cap_pkg::sat_add(pair_rdata, 2'd1);
                n_next         = n_reg + 1'b1;
                state_next     = S_OBUF;
            end
            S_OEND:
            begin
                req.buf_we    = 1'b1;
                req.buf_waddr = len_reg[cap_pkg::EXP_W-1:0];
                req.buf_wdata = f_reg;
                len_next      = last_reg ? '0 : len_reg + 1'b1;
                state_next    = S_IDLE;
            end
            S_PJ:
            begin
                req.fc_raddr = j_reg;
                state_next   = S_PJCHK;
            end
            S_PJCHK:
            begin
                if (known_reg[j_reg] || fc_rdata == '0)
                    state_next = S_PNEXT;
                else
                begin
                    sum_next   = '0;
                    k_next     = '0;
                    state_next = S_PK;
                end
            end
            S_PK:
            begin
                if (known_reg[k_reg])
                begin
                    req.fc_raddr   = k_reg;
                    req.pair_raddr = {k_reg, j_reg};
                    state_next     = S_PKD;
                end
                else if (&k_reg)
                    state_next = S_PAVG;
                else
                    k_next = k_reg + 1'b1;
            end
            S_PKD:
            begin
                div_start  = 1'b1;
                div_num    = {{cap_pkg::FEAT_W{1'b0}}, pair_rdata,
                              {cap_pkg::FRAC_W{1'b0}}};
                div_den    = fc_rdata;
                state_next = S_PKW;
            end
            S_PKW:
            begin
                if (div_done)
                begin
                    sum_next = sum_reg + div_quot;
                    if (&k_reg)
                        state_next = S_PAVG;
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_PK;
                    end
                end
            end
            S_PAVG:
            begin
                div_start  = 1'b1;
                div_num    = sum_reg;
                div_den    = cap_pkg::CNT_W'(set_reg);
                state_next = S_PAW;
            end
            S_PAW:
            begin
                if (div_done)
                begin
                    cand_next  = avg;
                    state_next = (avg > thresh_reg) ? S_PEMIT : S_PNEXT;
                end
            end
            S_PEMIT:
            begin
                if (!pend_v_reg)
                begin
                    pend_v_next = 1'b1;
                    pend_j_next = j_reg;
                    pend_s_next = cand_reg;
                    state_next  = S_PNEXT;
                end
                else if (out_free)
                begin
                    out_v_next  = 1'b1;
                    out_j_next  = pend_j_reg;
                    out_s_next  = pend_s_reg;
                    out_l_next  = 1'b0;
                    pend_j_next = j_reg;
                    pend_s_next = cand_reg;
                    state_next  = S_PNEXT;
                end
            end
            S_PNEXT:
            begin
                if (&j_reg)
                    state_next = S_PFIN;
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_PJ;
                end
            end
            S_PFIN:
            begin
                if (!pend_v_reg || out_free)
                begin
                    if (pend_v_reg)
                    begin
                        out_v_next = 1'b1;
                        out_j_next = pend_j_reg;
                        out_s_next = pend_s_reg;
                        out_l_next = 1'b1;
                    end
                    pend_v_next = 1'b0;
                    known_next  = '0;
                    set_next    = '0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            thresh_reg <= cap_pkg::THRESH_RESET;
            op_reg     <= 1'b0;
            f_reg      <= '0;
            last_reg   <= 1'b0;
            len_reg    <= '0;
            n_reg      <= '0;
            b_reg      <= '0;
            known_reg  <= '0;
            set_reg    <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            sum_reg    <= '0;
            cand_reg   <= '0;
            pend_v_reg <= 1'b0;
            pend_j_reg <= '0;
            pend_s_reg <= '0;
            out_v_reg  <= 1'b0;
            out_j_reg  <= '0;
            out_s_reg  <= '0;
            out_l_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            thresh_reg <= thresh_next;
            op_reg     <= op_next;
            f_reg      <= f_next;
            last_reg   <= last_next;
            len_reg    <= len_next;
            n_reg      <= n_next;
            b_reg      <= b_next;
            known_reg  <= known_next;
            set_reg    <= set_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            sum_reg    <= sum_next;
            cand_reg   <= cand_next;
            pend_v_reg <= pend_v_next;
            pend_j_reg <= pend_j_next;
            pend_s_reg <= pend_s_next;
            out_v_reg  <= out_v_next;
            out_j_reg  <= out_j_next;
            out_s_reg  <= out_s_next;
            out_l_reg  <= out_l_next;
        end
    end

    assign in_stall          = (state_reg != S_IDLE);
    assign out_valid         = out_v_reg;
    assign predicted_feature = out_j_reg;
    assign score             = out_s_reg;
    assign last_of_run       = out_l_reg;

endmodule
